[hdl/sfs_pkg.sv]
// Shared types, constants and helpers for the sprite frame sequencer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package sfs_pkg;

    // Sizing of the frame table and of the playback position
    localparam int MAX_FRAMES = 16;
    localparam int TIME_BITS  = 32;

    // Fixed widths of the interface fields
    localparam int ACTION_W   = 2;
    localparam int SLOT_W     = 4;
    localparam int LEN_W      = 32;
    localparam int STEP_W     = 32;
    localparam int SPEED_W    = 16;
    localparam int FCOUNT_W   = 5;
    localparam int CLIP_W     = 32;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_TIME_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Derived datapath widths
    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NCNT_W = $clog2(MAX_FRAMES + 1);
    localparam int ACC_W  = ((TIME_BITS > LEN_W) ? TIME_BITS : LEN_W) + IDX_W;
    localparam int PROD_W = TIME_BITS + SPEED_W;
    localparam int ADV_W  = PROD_W - 8;
    localparam int SUM_W  = ADV_W + 1;
    localparam int DCNT_W = $clog2(SUM_W);

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD = 2'd0,
        ACT_PLAY = 2'd1,
        ACT_STOP = 2'd2,
        ACT_TICK = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_LOOP_MODE     = 2'd0,
        REG_SPEED         = 2'd1,
        REG_FRAME_COUNT   = 2'd2,
        REG_CLIP_DURATION = 2'd3
    } reg_idx_t;

    localparam logic               RST_LOOP_MODE     = 1'b1;
    localparam logic [SPEED_W-1:0] RST_SPEED         = 16'd256;
    localparam logic [FCOUNT_W-1:0] RST_FRAME_COUNT  = 5'd1;
    localparam logic [CLIP_W-1:0]  RST_CLIP_DURATION = 32'd1;

    typedef struct packed {
        logic                loop_mode;
        logic [SPEED_W-1:0]  speed;
        logic [FCOUNT_W-1:0] frame_count;
        logic [CLIP_W-1:0]   clip_duration;
    } cfg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic add;
        logic div_step;
        logic walk_rd;
        logic walk_acc;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic adv_now;
        logic need_div;
        logic div_last;
        logic walk_last;
        logic walk_hit;
    } stat_t;

    // Frames in use: zero counts as one, clamp to the table depth
    function automatic logic [NCNT_W-1:0] frames_in_use(input logic [FCOUNT_W-1:0] fc);
        logic [NCNT_W-1:0] n;
        priority if (fc == '0) begin
            n = NCNT_W'(1);
        end else if (int'(fc) > MAX_FRAMES) begin
            n = NCNT_W'(MAX_FRAMES);
        end else begin
            n = NCNT_W'(fc);
        end
        return n;
    endfunction

endpackage

[hdl/sfs_regs.sv]
// APB-style configuration registers of the sprite frame sequencer.
// Depends on sfs_pkg for the register map, reset values and cfg_t.
module sfs_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output sfs_pkg::cfg_t                  cfg
);

    sfs_pkg::cfg_t     cfg_reg;
    sfs_pkg::cfg_t     cfg_next;
    sfs_pkg::reg_idx_t reg_sel;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_sel = sfs_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_sel)
                sfs_pkg::REG_LOOP_MODE:     cfg_next.loop_mode = pwdata[0];
                sfs_pkg::REG_SPEED:         cfg_next.speed = pwdata[sfs_pkg::SPEED_W-1:0];
                sfs_pkg::REG_FRAME_COUNT:
                    cfg_next.frame_count = pwdata[sfs_pkg::FCOUNT_W-1:0];
                sfs_pkg::REG_CLIP_DURATION:
                    cfg_next.clip_duration = pwdata[sfs_pkg::CLIP_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            sfs_pkg::REG_LOOP_MODE:     prdata = sfs_pkg::APB_DATA_W'(cfg_reg.loop_mode);
            sfs_pkg::REG_SPEED:         prdata = sfs_pkg::APB_DATA_W'(cfg_reg.speed);
            sfs_pkg::REG_FRAME_COUNT:   prdata = sfs_pkg::APB_DATA_W'(cfg_reg.frame_count);
            sfs_pkg::REG_CLIP_DURATION: prdata = sfs_pkg::APB_DATA_W'(cfg_reg.clip_duration);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.loop_mode     <= sfs_pkg::RST_LOOP_MODE;
            cfg_reg.speed         <= sfs_pkg::RST_SPEED;
            cfg_reg.frame_count   <= sfs_pkg::RST_FRAME_COUNT;
            cfg_reg.clip_duration <= sfs_pkg::RST_CLIP_DURATION;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/sfs_ctrl.sv]
// Controller state machine of the sprite frame sequencer.
// Depends on sfs_pkg for cmd_t and stat_t; drives the datapath by commands only.
module sfs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  sfs_pkg::stat_t stat,
    output sfs_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_MUL      = 7'b0000010,
        S_ADD      = 7'b0000100,
        S_DIV      = 7'b0001000,
        S_WALK_RD  = 7'b0010000,
        S_WALK_ACC = 7'b0100000,
        S_FIN      = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = stat.adv_now ? S_MUL : S_WALK_RD;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add    = 1'b1;
                state_next = stat.need_div ? S_DIV : S_WALK_RD;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (stat.walk_last) begin
                    state_next = S_FIN;
                end else begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WALK_ACC;
                end
            end
            S_WALK_ACC: begin
                cmd.walk_acc = 1'b1;
                state_next   = stat.walk_hit ? S_FIN : S_WALK_RD;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[hdl/sfs_dp.sv]
// Datapath of the sprite frame sequencer: frame table, position, advance,
// restoring remainder unit, frame walk and output register. Depends on sfs_pkg.
module sfs_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sfs_pkg::cfg_t                  cfg,
    input  sfs_pkg::cmd_t                  cmd,
    output sfs_pkg::stat_t                 stat,
    input  logic [sfs_pkg::ACTION_W-1:0]   s_action,
    input  logic [sfs_pkg::SLOT_W-1:0]     s_frame_slot,
    input  logic [sfs_pkg::LEN_W-1:0]      s_frame_length,
    input  logic [sfs_pkg::STEP_W-1:0]     s_step_time,
    output logic [sfs_pkg::OUT_IDX_W-1:0]  m_frame_index,
    output logic [sfs_pkg::OUT_TIME_W-1:0] m_elapsed_time,
    output logic                           m_is_playing,
    output logic                           m_is_visible
);

    localparam int TB = sfs_pkg::TIME_BITS;

    // Playback state
    logic [TB-1:0] pos_reg, pos_next;
    logic          run_reg, run_next;
    logic          shown_reg, shown_next;
    logic          skip_reg, skip_next;

    // Work registers
    logic [sfs_pkg::STEP_W-1:0]    step_reg;
    logic [sfs_pkg::PROD_W-1:0]    prod_reg;
    logic [sfs_pkg::SUM_W-1:0]     dvd_reg;
    logic [TB-1:0]                 rem_reg;
    logic [sfs_pkg::DCNT_W-1:0]    dcnt_reg;
    logic [sfs_pkg::IDX_W-1:0]     idx_reg;
    logic [sfs_pkg::ACC_W-1:0]     acc_reg;
    logic [sfs_pkg::LEN_W-1:0]     len_reg;
    logic [sfs_pkg::LEN_W-1:0]     len_mem [sfs_pkg::MAX_FRAMES];

    // Output register
    logic [sfs_pkg::OUT_IDX_W-1:0]  idx_out_reg;
    logic [sfs_pkg::OUT_TIME_W-1:0] time_out_reg;
    logic                           play_out_reg;
    logic                           vis_out_reg;

    sfs_pkg::action_t            action;
    logic [TB-1:0]               total;
    logic [sfs_pkg::ADV_W-1:0]   adv;
    logic [sfs_pkg::SUM_W-1:0]   sum;
    logic                        sum_ge_total;
    logic [TB:0]                 div_trial;
    logic                        div_ge;
    logic [TB-1:0]               rem_new;
    logic [sfs_pkg::NCNT_W-1:0]  n_frames;
    logic [sfs_pkg::ACC_W-1:0]   acc_sum;
    logic                        slot_ok;

    assign action       = sfs_pkg::action_t'(s_action);
    assign total        = TB'(cfg.clip_duration);
    assign adv          = prod_reg[sfs_pkg::PROD_W-1:8];
    assign sum          = sfs_pkg::SUM_W'(pos_reg) + sfs_pkg::SUM_W'(adv);
    assign sum_ge_total = (sum >= sfs_pkg::SUM_W'(total));

    // One remainder bit a cycle; the partial remainder stays below total
    assign div_trial = {rem_reg, dvd_reg[sfs_pkg::SUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, total});
    assign rem_new   = div_ge ? TB'(div_trial - {1'b0, total}) : div_trial[TB-1:0];

    assign n_frames = sfs_pkg::frames_in_use(cfg.frame_count);
    assign acc_sum  = acc_reg + sfs_pkg::ACC_W'(len_reg);
    assign slot_ok  = (int'(s_frame_slot) < sfs_pkg::MAX_FRAMES);

    assign stat.adv_now   = (action == sfs_pkg::ACT_TICK) && !skip_reg && run_reg
                            && (cfg.speed != '0);
    assign stat.need_div  = cfg.loop_mode && (total != '0) && sum_ge_total;
    assign stat.div_last  = (dcnt_reg == sfs_pkg::DCNT_W'(sfs_pkg::SUM_W - 1));
    assign stat.walk_last = ((sfs_pkg::NCNT_W'(idx_reg) + sfs_pkg::NCNT_W'(1)) >= n_frames);
    assign stat.walk_hit  = (sfs_pkg::ACC_W'(pos_reg) < acc_sum);

    always_comb begin
        pos_next   = pos_reg;
        run_next   = run_reg;
        shown_next = shown_reg;
        skip_next  = skip_reg;
        if (cmd.accept) begin
            unique case (action)
                sfs_pkg::ACT_PLAY: begin
                    pos_next   = '0;
                    run_next   = 1'b1;
                    shown_next = 1'b1;
                    skip_next  = 1'b1;
                end
                sfs_pkg::ACT_STOP: begin
                    run_next   = 1'b0;
                    shown_next = 1'b0;
                    skip_next  = 1'b0;
                end
                sfs_pkg::ACT_TICK: skip_next = 1'b0;
                default: skip_next = skip_reg;
            endcase
        end
        if (cmd.add) begin
            if (cfg.loop_mode) begin
                if (total == '0) begin
                    pos_next = '0;
                end else if (!sum_ge_total) begin
                    pos_next = TB'(sum);
                end
            end else if (sum_ge_total) begin
                // one-shot end: clamp and stop
                pos_next = total;
                run_next = 1'b0;
            end else begin
                pos_next = TB'(sum);
            end
        end
        if (cmd.div_step && stat.div_last) begin
            pos_next = rem_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            run_reg   <= 1'b0;
            shown_reg <= 1'b0;
            skip_reg  <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            run_reg   <= run_next;
            shown_reg <= shown_next;
            skip_reg  <= skip_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            step_reg <= s_step_time;
            idx_reg  <= '0;
            acc_reg  <= '0;
            if ((action == sfs_pkg::ACT_LOAD) && slot_ok) begin
                len_mem[sfs_pkg::IDX_W'(s_frame_slot)] <= s_frame_length;
            end
        end
        if (cmd.mul) begin
            prod_reg <= sfs_pkg::PROD_W'(TB'(step_reg)) * sfs_pkg::PROD_W'(cfg.speed);
        end
        if (cmd.add) begin
            dvd_reg  <= sum;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            dvd_reg  <= dvd_reg << 1;
            rem_reg  <= rem_new;
            dcnt_reg <= dcnt_reg + sfs_pkg::DCNT_W'(1);
        end
        if (cmd.walk_rd) begin
            len_reg <= len_mem[idx_reg];
        end
        if (cmd.walk_acc) begin
            acc_reg <= acc_sum;
            if (!stat.walk_hit) begin
                idx_reg <= idx_reg + sfs_pkg::IDX_W'(1);
            end
        end
        if (cmd.out_load) begin
            idx_out_reg  <= sfs_pkg::OUT_IDX_W'(idx_reg);
            time_out_reg <= sfs_pkg::OUT_TIME_W'(pos_reg);
            play_out_reg <= run_reg;
            vis_out_reg  <= shown_reg;
        end
    end

    assign m_frame_index  = idx_out_reg;
    assign m_elapsed_time = time_out_reg;
    assign m_is_playing   = play_out_reg;
    assign m_is_visible   = vis_out_reg;

endmodule

[hdl/sprite_frame_sequencer.sv]
// Flow: accept, for an advancing tick a multiply and an add, for a wrap a bit-serial
// remainder, then a walk over w frames (w = 0 .. MAX_FRAMES-1) and the output load.
// Throughput: one beat at a time; the next beat is taken the cycle after the result
// is loaded into the output register.
// Reset: aresetn synchronous, active low; clears position and flags, sets registers
// to their defaults; the frame table is not cleared and holds garbage until loaded.
module sprite_frame_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // input beats
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sfs_pkg::ACTION_W-1:0]   s_action,
    input  logic [sfs_pkg::SLOT_W-1:0]     s_frame_slot,
    input  logic [sfs_pkg::LEN_W-1:0]      s_frame_length,
    input  logic [sfs_pkg::STEP_W-1:0]     s_step_time,
    // result beats
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sfs_pkg::OUT_IDX_W-1:0]  m_frame_index,
    output logic [sfs_pkg::OUT_TIME_W-1:0] m_elapsed_time,
    output logic                           m_is_playing,
    output logic                           m_is_visible
);

    // The controller steps each beat through: accept (apply load, play or stop and
    // latch the tick step), for an advancing tick a multiply of step by speed and an
    // add of the advance to the position with clamp or wrap, an optional bit-serial
    // remainder for a wrap, then the walk over the frame table (one read and one
    // accumulate per frame), and finally the load of the output register. The output
    // register lets a new beat be accepted while the previous result still waits for m_ready.

    sfs_pkg::cfg_t  cfg;
    sfs_pkg::cmd_t  cmd;
    sfs_pkg::stat_t stat;

    sfs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: holds the frame table, position, flags and the result register
    sfs_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .stat           (stat),
        .s_action       (s_action),
        .s_frame_slot   (s_frame_slot),
        .s_frame_length (s_frame_length),
        .s_step_time    (s_step_time),
        .m_frame_index  (m_frame_index),
        .m_elapsed_time (m_elapsed_time),
        .m_is_playing   (m_is_playing),
        .m_is_visible   (m_is_visible)
    );

endmodule

[hdl/sfs_checker.sv]
// Port-level checks for the sprite frame sequencer, attached by bind.
// Depends on sfs_pkg for port widths.
module sfs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [sfs_pkg::OUT_IDX_W-1:0]  m_frame_index,
    input logic [sfs_pkg::OUT_TIME_W-1:0] m_elapsed_time,
    input logic                           m_is_playing,
    input logic                           m_is_visible
);

    // No result survives reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_elapsed_time)
                                && $stable(m_frame_index))
        else $error("stalled result changed");

    // One beat at a time: busy right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // A new result is only loaded from the busy side
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without work");

    // Only play sets playing, and play also shows the pose
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_is_playing || m_is_visible))
        else $error("playing while hidden");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_frame_index  (m_frame_index),
    .m_elapsed_time (m_elapsed_time),
    .m_is_playing   (m_is_playing),
    .m_is_visible   (m_is_visible)
);

[tb/sv/tb.sv]
// Self-checking bench for sprite_frame_sequencer: frame-table loads, play, stop and tick beats
// checked against a built-in playback predictor. Needs sfs_pkg and the block's RTL only.
module tb;
    import sfs_pkg::*;

    // One input beat, one result beat, and one row of the opening stimulus table
    typedef struct packed {
        action_t     act;
        logic [3:0]  slot;
        logic [31:0] length;
        logic [31:0] step;
    } cue_t;

    typedef struct packed {
        logic [3:0]  frame;
        logic [31:0] elapsed;
        logic        playing;
        logic        visible;
    } pose_t;

    typedef struct packed {
        cue_t  cue;
        logic  pinned;   // pose below is typed in; otherwise take the predictor's
        pose_t pose;
    } opening_row_t;

    localparam int PHASES = 12;

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [ACTION_W-1:0]   s_action       = '0;
    logic [SLOT_W-1:0]     s_frame_slot   = '0;
    logic [LEN_W-1:0]      s_frame_length = '0;
    logic [STEP_W-1:0]     s_step_time    = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [OUT_IDX_W-1:0]  m_frame_index;
    logic [OUT_TIME_W-1:0] m_elapsed_time;
    logic                  m_is_playing;
    logic                  m_is_visible;

    sprite_frame_sequencer dut (.*);

    // Predictor copy of the playback state and of the registers
    logic [31:0] lengths_seen [MAX_FRAMES];
    logic [31:0] play_pos    = '0;
    logic        running     = 1'b0;
    logic        shown       = 1'b0;
    logic        skip_tick   = 1'b0;
    logic        loop_cfg    = RST_LOOP_MODE;
    logic [15:0] speed_cfg   = RST_SPEED;
    logic [4:0]  frames_cfg  = RST_FRAME_COUNT;
    logic [31:0] clip_cfg    = RST_CLIP_DURATION;

    pose_t pending_poses [$];
    int    fault_count     = 0;
    bit    sender_idles    = 1'b1;
    bit    receiver_stalls = 1'b1;
    int    hold_request    = 0;

    // Opening table, run under the reset settings (one frame, looping, unit clip).
    // With one frame in use no table entry is read, so the loads may come in any order.
    opening_row_t opening_rows [24] = '{
        // tick straight after reset: stopped, so nothing moves
        '{'{ACT_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF}, 1'b1, '{4'd0, 32'd0, 1'b0, 1'b0}},
        '{'{ACT_STOP, 4'd0, 32'd0, 32'd0},         1'b1, '{4'd0, 32'd0, 1'b0, 1'b0}},
        '{'{ACT_PLAY, 4'd0, 32'd0, 32'd0},         1'b1, '{4'd0, 32'd0, 1'b1, 1'b1}},
        // first tick after play is swallowed
        '{'{ACT_TICK, 4'd0, 32'd0, 32'd5},         1'b1, '{4'd0, 32'd0, 1'b1, 1'b1}},
        // largest step wraps to zero on a unit clip
        '{'{ACT_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF}, 1'b1, '{4'd0, 32'd0, 1'b1, 1'b1}},
        '{'{ACT_TICK, 4'd0, 32'd0, 32'd0},         1'b1, '{4'd0, 32'd0, 1'b1, 1'b1}},
        '{'{ACT_LOAD, 4'd0, 32'hFFFF_FFFF, 32'd0}, 1'b1, '{4'd0, 32'd0, 1'b1, 1'b1}},
        '{'{ACT_LOAD, 4'd15, 32'd0, 32'd0},        1'b1, '{4'd0, 32'd0, 1'b1, 1'b1}},
        '{'{ACT_LOAD, 4'd1, 32'd3, 32'd0},         1'b0, '0},
        '{'{ACT_LOAD, 4'd2, 32'd17, 32'd0},        1'b0, '0},
        '{'{ACT_LOAD, 4'd3, 32'd1, 32'd0},         1'b0, '0},
        '{'{ACT_LOAD, 4'd4, 32'd250, 32'd0},       1'b0, '0},
        '{'{ACT_LOAD, 4'd5, 32'd40, 32'd0},        1'b0, '0},
        '{'{ACT_LOAD, 4'd6, 32'hA5A5_5A5A, 32'd0}, 1'b0, '0},
        '{'{ACT_LOAD, 4'd7, 32'd9, 32'd0},         1'b0, '0},
        '{'{ACT_LOAD, 4'd8, 32'd64, 32'd0},        1'b0, '0},
        '{'{ACT_LOAD, 4'd9, 32'd2, 32'd0},         1'b0, '0},
        '{'{ACT_LOAD, 4'd10, 32'd100, 32'd0},      1'b0, '0},
        '{'{ACT_LOAD, 4'd11, 32'd7, 32'd0},        1'b0, '0},
        '{'{ACT_LOAD, 4'd12, 32'd33, 32'd0},       1'b0, '0},
        '{'{ACT_LOAD, 4'd13, 32'd5, 32'd0},        1'b0, '0},
        '{'{ACT_LOAD, 4'd14, 32'd128, 32'd0},      1'b0, '0},
        '{'{ACT_STOP, 4'd0, 32'd0, 32'd0},         1'b1, '{4'd0, 32'd0, 1'b0, 1'b0}},
        '{'{ACT_TICK, 4'd0, 32'd0, 32'd3},         1'b1, '{4'd0, 32'd0, 1'b0, 1'b0}}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Frames in use: a count of zero behaves as one, anything past the table depth is clamped
    function automatic int frames_live(input logic [4:0] fc);
        if (fc == '0) return 1;
        if (int'(fc) > MAX_FRAMES) return MAX_FRAMES;
        return int'(fc);
    endfunction

    // Apply one beat to the predicted playback and return the pose it should report
    function automatic pose_t next_pose(input cue_t c);
        logic [63:0] adv;
        logic [63:0] total;
        logic [63:0] pos;
        logic [63:0] acc;
        int          n;
        int          idx;
        bit          hit;
        pose_t       p;
        case (c.act)
            ACT_LOAD: lengths_seen[c.slot] = c.length;
            ACT_PLAY: begin
                play_pos  = '0;
                running   = 1'b1;
                shown     = 1'b1;
                skip_tick = 1'b1;
            end
            ACT_STOP: begin
                running   = 1'b0;
                shown     = 1'b0;
                skip_tick = 1'b0;
            end
            ACT_TICK: begin
                if (skip_tick) begin
                    skip_tick = 1'b0;
                end else if (running && speed_cfg != '0) begin
                    // advance = step * speed in Q8.8, truncated
                    adv   = (64'(c.step) * 64'(speed_cfg)) >> 8;
                    total = 64'(clip_cfg);
                    pos   = 64'(play_pos);
                    if (loop_cfg) begin
                        pos = (total == 0) ? 64'd0 : (pos + adv) % total;
                    end else if (pos >= total || adv >= total - pos) begin
                        // one-shot end: clamp to the clip length and stop
                        pos     = total;
                        running = 1'b0;
                    end else begin
                        pos = pos + adv;
                    end
                    play_pos = pos[31:0];
                end
            end
        endcase
        // Walk the cumulative frame ends; fall back to the last frame in use
        n   = frames_live(frames_cfg);
        idx = n - 1;
        hit = 1'b0;
        acc = '0;
        for (int i = 0; i < MAX_FRAMES - 1; i++) begin
            if (!hit && i < n - 1) begin
                acc += 64'(lengths_seen[i]);
                if (64'(play_pos) < acc) begin
                    idx = i;
                    hit = 1'b1;
                end
            end
        end
        p.frame   = 4'(idx);
        p.elapsed = play_pos;
        p.playing = running;
        p.visible = shown;
        return p;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
        fault_count++;
    endtask

    // Offer one beat, idling first now and then. Valid stays high from beat to beat
    // unless a gap is taken, so it is never dropped and raised in one step.
    task automatic offer_cue(input cue_t c, input logic pinned, input pose_t typed);
        pose_t p;
        if (sender_idles && $urandom_range(0, 99) < 26) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 60);
        end
        s_valid        <= 1'b1;
        s_action       <= c.act;
        s_frame_slot   <= c.slot;
        s_frame_length <= c.length;
        s_step_time    <= c.step;
        do @(posedge aclk); while (!s_ready);
        p = next_pose(c);
        pending_poses.push_back(pinned ? typed : p);
    endtask

    // Drop valid and hold until every predicted pose has come back
    task automatic await_results();
        s_valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input reg_idx_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (r)
            REG_LOOP_MODE:     loop_cfg   = v[0];
            REG_SPEED:         speed_cfg  = v[15:0];
            REG_FRAME_COUNT:   frames_cfg = v[4:0];
            REG_CLIP_DURATION: clip_cfg   = v;
        endcase
        @(posedge aclk);
    endtask

    task automatic check_register(input reg_idx_t r, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) flag_mismatch(r.name(), prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_playback(input logic lp, input logic [15:0] sp, input logic [4:0] fc,
                                input logic [31:0] cd);
        write_register(REG_LOOP_MODE, 32'(lp));
        write_register(REG_SPEED, 32'(sp));
        write_register(REG_FRAME_COUNT, 32'(fc));
        write_register(REG_CLIP_DURATION, cd);
        check_register(REG_LOOP_MODE, 32'(loop_cfg));
        check_register(REG_SPEED, 32'(speed_cfg));
        check_register(REG_FRAME_COUNT, 32'(frames_cfg));
        check_register(REG_CLIP_DURATION, clip_cfg);
    endtask

    // Result side: stall at random, or hold off for a requested number of cycles
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= !(receiver_stalls && $urandom_range(0, 99) < 26);
            end
        end
    end

    // Compare every accepted result beat with the oldest predicted pose
    always @(posedge aclk) begin : result_check
        pose_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_poses.size() == 0) begin
                flag_mismatch("unexpected result beat", m_elapsed_time, 32'd0);
            end else begin
                want = pending_poses.pop_front();
                if (m_frame_index !== want.frame)
                    flag_mismatch("frame_index", 32'(m_frame_index), 32'(want.frame));
                if (m_elapsed_time !== want.elapsed)
                    flag_mismatch("elapsed_time", m_elapsed_time, want.elapsed);
                if (m_is_playing !== want.playing)
                    flag_mismatch("is_playing", 32'(m_is_playing), 32'(want.playing));
                if (m_is_visible !== want.visible)
                    flag_mismatch("is_visible", 32'(m_is_visible), 32'(want.visible));
            end
        end
    end

    initial begin : stimulus
        logic [31:0] lens [MAX_FRAMES];
        logic [63:0] sum;
        logic [63:0] aim;
        logic        loop_v;
        logic [15:0] speed_v;
        logic [4:0]  frames_v;
        logic [31:0] clip_v;
        cue_t        c;
        int          n;
        int          r;
        int          budget;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers must come out of reset at their defaults
        check_register(REG_LOOP_MODE, 32'(RST_LOOP_MODE));
        check_register(REG_SPEED, 32'(RST_SPEED));
        check_register(REG_FRAME_COUNT, 32'(RST_FRAME_COUNT));
        check_register(REG_CLIP_DURATION, RST_CLIP_DURATION);

        // Opening table also fills every frame entry before more frames come into use
        foreach (opening_rows[k])
            offer_cue(opening_rows[k].cue, opening_rows[k].pinned, opening_rows[k].pose);
        await_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            // Early phases pin the corner settings; the rest pick at random
            case (ph)
                0: begin loop_v = 1'b0; speed_v = 16'd256;  frames_v = 5'd4;  end
                1: begin loop_v = 1'b1; speed_v = 16'd0;    frames_v = 5'd16; end
                2: begin loop_v = 1'b1; speed_v = 16'hFFFF; frames_v = 5'd31; end
                3: begin loop_v = 1'b1; speed_v = 16'd256;  frames_v = 5'd0;  end
                4: begin loop_v = 1'b0; speed_v = 16'd512;  frames_v = 5'd16; end
                5: begin loop_v = 1'b1; speed_v = 16'd1;    frames_v = 5'd16; end
                default: begin
                    loop_v = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 3))
                        0:       speed_v = 16'd256;
                        1:       speed_v = 16'($urandom_range(64, 1024));
                        2:       speed_v = 16'($urandom);
                        default: speed_v = 16'($urandom_range(1, 255));
                    endcase
                    frames_v = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                           : 5'($urandom_range(1, 16));
                end
            endcase

            // Pick this phase's frame lengths; mostly short so the walk lands mid-table
            n   = frames_live(frames_v);
            sum = '0;
            for (int k = 0; k < n; k++) begin
                r       = $urandom_range(0, 9);
                lens[k] = (r == 0) ? 32'd0 : (r == 1) ? 32'($urandom)
                                                      : 32'($urandom_range(1, 255));
                sum    += 64'(lens[k]);
            end
            case (ph)
                2:       clip_v = 32'hFFFF_FFFF;
                3, 4:    clip_v = 32'd0;
                default: clip_v = (ph < 6 || $urandom_range(0, 9) < 7) ? sum[31:0]
                                                                      : 32'($urandom);
            endcase
            set_playback(loop_v, speed_v, frames_v, clip_v);

            // One phase runs flat out on both sides
            sender_idles    = (ph != 3);
            receiver_stalls = (ph != 3);

            for (int k = 0; k < n; k++) begin
                c = '{ACT_LOAD, 4'(k), lens[k], 32'($urandom)};
                offer_cue(c, 1'b0, '0);
            end
            c = '{ACT_PLAY, 4'($urandom), 32'($urandom), 32'($urandom)};
            offer_cue(c, 1'b0, '0);

            // Stop draining results for a long while so the block backs up
            if (ph == 6) hold_request = 400;

            budget = 32 - n;
            for (int k = 0; k < budget; k++) begin
                // Now and then hold the input until everything has come back
                if (k == budget / 2 && ph % 4 == 1) await_results();
                c = '{ACT_TICK, 4'($urandom), 32'($urandom), 32'($urandom)};
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    r = $urandom_range(0, 99);
                    if (r < 5) begin
                        c.step = '0;
                    end else if (r < 10) begin
                        c.step = '1;
                    end else if (r < 40) begin
                        c.step = (r < 25) ? 32'($urandom) : 32'($urandom_range(0, 15));
                    end else begin
                        // Size the step against the clip so wraps and clamps both happen
                        aim = (64'(clip_cfg) * $urandom_range(0, loop_cfg ? 160 : 40)) / 100;
                        if (speed_cfg != '0) aim = (aim << 8) / 64'(speed_cfg);
                        c.step = (aim > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : aim[31:0];
                    end
                end else if (r < 75) begin
                    c.act = ACT_PLAY;
                end else if (r < 83) begin
                    c.act = ACT_STOP;
                end else begin
                    c.act = ACT_LOAD;
                end
                offer_cue(c, 1'b0, '0);
            end
            await_results();
        end

        // Let any stray beat show up before deciding
        repeat (100) @(posedge aclk);
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
